// ===== rtl/lzd_pkg.sv =====
// Shared types and constants for the LZ77 byte decompressor.
package lzd_pkg;

	// Default history size in bytes.
	localparam int unsigned WINDOW_BYTES_DEF = 4096;

	// Token format constants.
	localparam int unsigned OFFSET_W = 12;
	localparam int unsigned COUNT_W  = 5;
	localparam logic [COUNT_W-1:0] COUNT_BIAS = 5'd3;
	localparam logic [3:0] FLAGS_PER_BYTE = 4'd8;

	// Work handed from the parser to the copy engine.
	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_LIT  = 2'd1,
		CMD_COPY = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t             kind;
		logic [7:0]            lit;
		logic [OFFSET_W-1:0]   offset;
		logic [COUNT_W-1:0]    count;
	} lzd_cmd_t;

endpackage

// ===== rtl/lzd_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lzd_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/lzd_parser.sv =====
// Header, flag and token parser with the remaining-length counter.
module lzd_parser
	import lzd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       start_req,
	input  logic       emit,
	output lzd_cmd_t   cmd,
	output logic       rem_last
);

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_BODY   = 4'b0100,
		PH_TOKEN2 = 4'b1000
	} phase_t;

	phase_t      phase_q;
	phase_t      phase_eff;
	logic [1:0]  hdr_cnt_q;
	logic [23:0] rem_q;
	logic [7:0]  flag_bits_q;
	logic [3:0]  flags_left_q;
	logic [7:0]  token_high_q;

	// A body phase with nothing left to produce behaves as idle.
	always_comb begin
		phase_eff = phase_q;
		if (phase_q == PH_BODY && rem_q == 24'd0) begin
			phase_eff = PH_IDLE;
		end
	end

	assign rem_last = (rem_q == 24'd1);

	// Command for the engine, raised only on an accepted request.
	always_comb begin
		cmd.kind   = CMD_NONE;
		cmd.lit    = in_byte;
		cmd.offset = {token_high_q[3:0], in_byte};
		cmd.count  = COUNT_W'(token_high_q[7:4]) + COUNT_BIAS;
		if (accept && !start_req) begin
			if (phase_eff == PH_BODY && flags_left_q != 4'd0 && !flag_bits_q[7]) begin
				cmd.kind = CMD_LIT;
			end else if (phase_eff == PH_TOKEN2) begin
				cmd.kind = CMD_COPY;
			end
		end
	end

	// Parser state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			hdr_cnt_q    <= 2'd0;
			rem_q        <= 24'd0;
			flag_bits_q  <= 8'd0;
			flags_left_q <= 4'd0;
			token_high_q <= 8'd0;
		end else if (accept) begin
			if (start_req) begin
				phase_q      <= PH_HEADER;
				hdr_cnt_q    <= 2'd0;
				rem_q        <= 24'd0;
				flag_bits_q  <= 8'd0;
				flags_left_q <= 4'd0;
			end else begin
				unique case (phase_eff)
					PH_IDLE: begin
					end
					PH_HEADER: begin
						unique case (hdr_cnt_q)
							2'd0:    rem_q[7:0]   <= in_byte;
							2'd1:    rem_q[15:8]  <= in_byte;
							default: rem_q[23:16] <= in_byte;
						endcase
						if (hdr_cnt_q >= 2'd2) begin
							hdr_cnt_q    <= 2'd0;
							flags_left_q <= 4'd0;
							phase_q      <= PH_BODY;
						end else begin
							hdr_cnt_q <= hdr_cnt_q + 2'd1;
						end
					end
					PH_BODY: begin
						if (flags_left_q == 4'd0) begin
							flag_bits_q  <= in_byte;
							flags_left_q <= FLAGS_PER_BYTE;
						end else if (!flag_bits_q[7]) begin
							flag_bits_q  <= {flag_bits_q[6:0], 1'b0};
							flags_left_q <= flags_left_q - 4'd1;
						end else begin
							token_high_q <= in_byte;
							phase_q      <= PH_TOKEN2;
						end
					end
					PH_TOKEN2: begin
						flag_bits_q  <= {flag_bits_q[6:0], 1'b0};
						flags_left_q <= flags_left_q - 4'd1;
						phase_q      <= PH_BODY;
					end
					default: begin
					end
				endcase
			end
		end else if (emit) begin
			rem_q <= rem_q - 24'd1;
		end
	end

endmodule

// ===== rtl/lzd_engine.sv =====
// Copy engine: history clearing, literal and back-reference output, output register.
module lzd_engine
	import lzd_pkg::*;
#(
	parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lzd_cmd_t   cmd,
	input  logic       rem_last,
	output logic       in_ready,
	output logic       emit,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       out_done
);

	localparam int unsigned AddrW = $clog2(WINDOW_BYTES);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_LIT   = 5'b00100,
		ST_RD    = 5'b01000,
		ST_WR    = 5'b10000
	} state_t;

	state_t             state_q;
	logic [AddrW-1:0]   clr_q;
	logic [AddrW-1:0]   wp_q;
	logic [AddrW-1:0]   dist_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [7:0]         lit_q;
	logic               out_valid_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;
	logic               out_done_q;

	logic               slot_free;
	logic               emit_last;
	logic [7:0]         emit_byte;
	logic               ram_we;
	logic [AddrW-1:0]   ram_waddr;
	logic [7:0]         ram_wdata;
	logic               ram_re;
	logic [AddrW-1:0]   ram_raddr;
	logic [7:0]         ram_rdata;

	assign in_ready  = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign emit      = (state_q == ST_LIT || state_q == ST_WR) && slot_free;
	assign emit_byte = (state_q == ST_LIT) ? lit_q : ram_rdata;
	assign emit_last = (state_q == ST_LIT) || (cnt_q == COUNT_W'(1)) || rem_last;

	// A subtractor forms the history read address.
	assign ram_re    = (state_q == ST_RD);
	assign ram_raddr = wp_q - dist_q;

	// History write: zeros during the clearing pass, else the emitted byte.
	always_comb begin
		ram_we    = emit;
		ram_waddr = wp_q;
		ram_wdata = emit_byte;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 8'd0;
		end
	end

	lzd_ram #(
		.Width(8),
		.Depth(WINDOW_BYTES)
	) u_history (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wp_q    <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AddrW'(1);
					if (clr_q == AddrW'(WINDOW_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.kind == CMD_LIT) begin
						state_q <= ST_LIT;
					end else if (cmd.kind == CMD_COPY) begin
						cnt_q   <= cmd.count;
						state_q <= ST_RD;
					end
				end
				ST_LIT: begin
					if (slot_free) begin
						wp_q    <= wp_q + AddrW'(1);
						state_q <= ST_IDLE;
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (slot_free) begin
						wp_q  <= wp_q + AddrW'(1);
						cnt_q <= cnt_q - COUNT_W'(1);
						state_q <= emit_last ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command payload, captured when the engine takes a command.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			lit_q  <= cmd.lit;
			dist_q <= AddrW'({1'b0, cmd.offset} + 13'd1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
			out_done_q <= rem_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_done  = out_done_q;

`ifndef NO_ASSERTIONS
	// No output appears while the history is being cleared.
	a_no_out_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid_q)
		else $error("output valid during clearing pass");

	// A copy never runs with an exhausted count.
	a_copy_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_WR) |-> (cnt_q != '0))
		else $error("copy with zero count");

	// The final byte of a request returns the engine to idle.
	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == ST_IDLE))
		else $error("engine busy after last byte");

	// A stream-done byte always closes its request.
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_done_q) |-> out_last_q)
		else $error("stream done without last");
`endif

endmodule

// ===== rtl/lz77_byte_decompressor.sv =====
// Top level of the LZ77 byte decompressor.
// Decodes an LZ77 stream in the common handheld BIOS format, one compressed
// byte per request on the slave side and one decoded byte per request on the
// master side. After reset the history of WINDOW_BYTES bytes (4096 by default)
// is cleared, during which no input is taken. A header byte, a flag byte or the
// first byte of a reference produces no output; a literal produces one byte;
// the second byte of a reference copies up to count bytes (3 to 18), each one
// a read and then a write of the single history RAM. Output stalls hold the
// engine and the input. A byte with tuser set starts a new stream; tlast marks
// the last byte produced by one input request.
module lz77_byte_decompressor
	import lzd_pkg::*;
#(
	parameter int unsigned WINDOW_BYTES = WINDOW_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tuser,   // [0] start_req
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast,
	output logic       m_axis_tuser    // [0] stream_done
);

	lzd_cmd_t cmd;
	logic     accept;
	logic     emit;
	logic     rem_last;

	assign accept = s_axis_tvalid && s_axis_tready;

	// Stream parser.
	lzd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (s_axis_tdata),
		.start_req (s_axis_tuser),
		.emit      (emit),
		.cmd       (cmd),
		.rem_last  (rem_last)
	);

	// History and output sequencer.
	lzd_engine #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rem_last  (rem_last),
		.in_ready  (s_axis_tready),
		.emit      (emit),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_done  (m_axis_tuser)
	);

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the LZ77 byte decompressor: directed and random streams.
`timescale 1ns / 1ps

module tb;
	import lzd_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int RX_LONG_HOLD   = 400;
	localparam int RANDOM_ITEMS   = 260;
	localparam int SETTLE_CYCLES  = 100;

	// Decoder phases tracked by the predictor.
	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HEADER = 2'd1,
		PH_BODY   = 2'd2,
		PH_REF2   = 2'd3
	} dec_phase_t;

	// One decoded byte as it should leave the master side.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       done;
	} out_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
	logic       s_axis_tuser = 1'b0;    // [0] start_req
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] out_byte
	logic       m_axis_tlast;
	logic       m_axis_tuser;           // [0] stream_done

	// Decoder state mirrored by the predictor.
	dec_phase_t  dec_phase = PH_IDLE;
	logic [1:0]  hdr_cnt = '0;
	logic [23:0] remaining = '0;
	logic [7:0]  flags = '0;
	logic [3:0]  flags_left = '0;
	logic [7:0]  ref_hi = '0;
	logic [11:0] wr_ptr = '0;
	logic [7:0]  history_mem [WINDOW_BYTES_DEF];

	out_beat_t expected_bytes [$];
	out_beat_t chk_beat;

	int  tx_idle_pct = 0;
	int  rx_idle_pct = 0;
	bit  rx_long_hold = 1'b0;
	int  errors = 0;
	int  items_sent = 0;
	int  bytes_checked = 0;
	int  streams_sent = 0;
	int  restarts = 0;
	int  quiet_cycles = 0;

	lz77_byte_decompressor u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

	// Clock with a 2 ns period.
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Write one decoded byte into the history and queue it as expected.
	task put_history_byte(input logic [7:0] v);
		history_mem[wr_ptr] = v;
		wr_ptr = wr_ptr + 12'd1;
		remaining = remaining - 24'd1;
		expected_bytes.push_back('{data: v, last: 1'b0, done: remaining == 24'd0});
	endtask

	// Retire one flag bit; the stream ends once the length is used up.
	task retire_flag();
		flags = flags << 1;
		flags_left = flags_left - 4'd1;
		if (remaining == 24'd0)
			dec_phase = PH_IDLE;
	endtask

	// Advance the decoder model by one accepted request and queue its output bytes.
	task decode_request(input logic [7:0] b, input logic st, output bit ignored);
		int          n0;
		logic [12:0] ref_dist;
		logic [4:0]  cnt;
		logic [11:0] idx;
		out_beat_t   tail;
		n0 = expected_bytes.size();
		ignored = 1'b0;
		if (st) begin
			dec_phase = PH_HEADER;
			hdr_cnt = '0;
			remaining = '0;
			flags = '0;
			flags_left = '0;
		end else begin
			case (dec_phase)
				PH_IDLE: ignored = 1'b1;
				PH_HEADER: begin
					remaining = remaining | (24'(b) << (8 * hdr_cnt));
					if (hdr_cnt >= 2'd2) begin
						hdr_cnt = '0;
						flags_left = '0;
						dec_phase = (remaining != 24'd0) ? PH_BODY : PH_IDLE;
					end else begin
						hdr_cnt = hdr_cnt + 2'd1;
					end
				end
				PH_BODY: begin
					if (flags_left == 4'd0) begin
						flags = b;
						flags_left = FLAGS_PER_BYTE;
					end else if (!flags[7]) begin
						put_history_byte(b);
						retire_flag();
					end else begin
						ref_hi = b;
						dec_phase = PH_REF2;
					end
				end
				PH_REF2: begin
					ref_dist = {1'b0, ref_hi[3:0], b} + 13'd1;
					cnt = 5'(ref_hi[7:4]) + COUNT_BIAS;
					while (cnt != 5'd0 && remaining != 24'd0) begin
						idx = wr_ptr - ref_dist[11:0];
						put_history_byte(history_mem[idx]);
						cnt = cnt - 5'd1;
					end
					dec_phase = PH_BODY;
					retire_flag();
				end
			endcase
		end
		// The final byte caused by this request carries tlast.
		if (expected_bytes.size() > n0) begin
			tail = expected_bytes.pop_back();
			tail.last = 1'b1;
			expected_bytes.push_back(tail);
		end
	endtask

	// Offer one compressed byte, wait for the request to be taken, then maybe idle.
	task send_byte(input logic [7:0] b, input logic st);
		int gap;
		bit ign;
		s_axis_tdata <= b;
		s_axis_tuser <= st;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		decode_request(b, st, ign);
		if (!ign)
			items_sent++;
		gap = pick_gap(tx_idle_pct);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every expected byte has come out.
	task wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	// Send a well-formed stream with random tokens; abort_at >= 0 restarts it early.
	task send_stream(input int len, input int abort_at);
		int         k;
		int         d;
		int         r;
		logic [7:0] hi;
		streams_sent++;
		send_byte(8'($urandom), 1'b1);
		send_byte(len[7:0], 1'b0);
		send_byte(len[15:8], 1'b0);
		send_byte(len[23:16], 1'b0);
		k = 0;
		while (dec_phase != PH_IDLE) begin
			if (k == abort_at) begin
				send_byte(8'($urandom), 1'b1);
				restarts++;
				return;
			end
			k++;
			if (flags_left == 4'd0) begin
				send_byte(8'($urandom), 1'b0);
			end else if (!flags[7]) begin
				send_byte(8'($urandom), 1'b0);
			end else begin
				// Mostly near references, some far ones across the whole window.
				r = $urandom_range(99);
				if (r < 70)
					d = $urandom_range(0, 15);
				else if (r < 90)
					d = $urandom_range(0, 255);
				else
					d = $urandom_range(0, 4095);
				hi = {4'($urandom_range(15)), 4'(d >> 8)};
				send_byte(hi, 1'b0);
				send_byte(8'(d), 1'b0);
			end
		end
	endtask

	// Output side: random stalls, plus one long hold when asked for.
	initial begin : rx_side
		int hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = rx_long_hold ? RX_LONG_HOLD : pick_gap(rx_idle_pct);
			rx_long_hold = 1'b0;
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Compare every output request with the oldest expected byte.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected output byte %02h", m_axis_tdata);
				errors++;
			end else begin
				chk_beat = expected_bytes.pop_front();
				bytes_checked++;
				if (chk_beat.data !== m_axis_tdata) begin
					$error("out_byte: expected %02h, got %02h", chk_beat.data, m_axis_tdata);
					errors++;
				end
				if (chk_beat.last !== m_axis_tlast) begin
					$error("last_of_run: expected %0b, got %0b", chk_beat.last, m_axis_tlast);
					errors++;
				end
				if (chk_beat.done !== m_axis_tuser) begin
					$error("stream_done: expected %0b, got %0b", chk_beat.done, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	// Stop the run when neither side has moved a request for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: errors");
				$finish;
			end
		end
	end

	// Bytes before any header are dropped.
	task test_idle_bytes_ignored();
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
	endtask

	// Literal and reference extremes; the longest, farthest reference reads cleared history.
	task test_extremes_and_early_history();
		streams_sent++;
		send_byte(8'h10, 1'b1);
		send_byte(8'h16, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h40, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b0);
	endtask

	// A header of length zero produces nothing and goes back to idle.
	task test_zero_length();
		streams_sent++;
		send_byte(8'h10, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h5A, 1'b0);
	endtask

	// Restart while waiting for the second byte of a reference in a huge stream.
	task test_restart_mid_reference();
		streams_sent++;
		send_byte(8'h10, 1'b1);
		send_byte(8'h34, 1'b0);
		send_byte(8'h12, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h0A, 1'b0);
		send_byte(8'h10, 1'b1);
		restarts++;
	endtask

	// The length runs out inside a reference; following bytes are dropped.
	task test_truncated_reference();
		send_byte(8'h05, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b0);
	endtask

	// Hold the output for a long stretch while input keeps coming.
	task test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_long_hold = 1'b1;
		send_stream(200, -1);
	endtask

	// Let the decoder drain completely between two streams.
	task test_pause_until_drained();
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		send_stream(30, -1);
		wait_drained();
		send_stream(30, -1);
	endtask

	// Random streams with noise, restarts and trailing bytes.
	task test_random_streams();
		int first_item;
		int len;
		int r;
		int abort_at;
		first_item = items_sent;
		while (items_sent - first_item < RANDOM_ITEMS) begin
			tx_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
			rx_idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 50);
			if ($urandom_range(9) == 0)
				send_byte(8'($urandom), 1'b0);
			r = $urandom_range(99);
			if (r < 10)
				len = 0;
			else if (r < 85)
				len = $urandom_range(1, 40);
			else
				len = $urandom_range(41, 300);
			abort_at = ($urandom_range(9) == 0) ? $urandom_range(0, 10) : -1;
			send_stream(len, abort_at);
			if ($urandom_range(4) == 0) begin
				repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < WINDOW_BYTES_DEF; i++)
			history_mem[i] = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_idle_bytes_ignored();
		test_extremes_and_early_history();
		test_zero_length();
		test_restart_mid_reference();
		test_truncated_reference();
		test_output_backpressure();
		test_pause_until_drained();
		test_random_streams();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("summary: %0d streams (%0d restarted), %0d decoded input bytes, %0d output bytes",
			streams_sent, restarts, items_sent, bytes_checked);
		$display("summary: literals, references, zero length, truncation, long output stall");
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
